>>> rtl/gpio_prb_pkg.sv
package gpio_prb_pkg;

  localparam int PORT_COUNT_DEF = 5;
  localparam int PINS_PER_PORT_DEF = 16;
  localparam int PIN_W = 16;
  localparam int WORD_W = 32;
  localparam int PORT_SEL_W = 5;
  localparam int KEY_BIT = 16;
  localparam logic [3:0] AF_MASK = 4'hF;

  localparam logic [3:0] REG_MODE = 4'd0;
  localparam logic [3:0] REG_TYPE = 4'd1;
  localparam logic [3:0] REG_SPEED = 4'd2;
  localparam logic [3:0] REG_PULL = 4'd3;
  localparam logic [3:0] REG_INPUT = 4'd4;
  localparam logic [3:0] REG_OUTPUT = 4'd5;
  localparam logic [3:0] REG_SETRESET = 4'd6;
  localparam logic [3:0] REG_LOCK = 4'd7;
  localparam logic [3:0] REG_AFLOW = 4'd8;
  localparam logic [3:0] REG_AFHIGH = 4'd9;

  typedef struct packed {
    logic capture;
    logic execute;
  } prb_cmd_t;

  function automatic logic [WORD_W-1:0] spread2(input logic [PIN_W-1:0] bits);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int p = 0; p < PIN_W; p++) begin
      r[2*p +: 2] = {2{bits[p]}};
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] spread4(input logic [7:0] bits);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int p = 0; p < 8; p++) begin
      r[4*p +: 4] = bits[p] ? AF_MASK : 4'h0;
    end
    return r;
  endfunction

  function automatic logic [PIN_W-1:0] outputs_enabled(input logic [WORD_W-1:0] mw);
    logic [PIN_W-1:0] r;
    for (int p = 0; p < PIN_W; p++) begin
      r[p] = (mw[2*p +: 2] == 2'b01);
    end
    return r;
  endfunction

endpackage

>>> rtl/gpio_port_register_block.sv
// Channel  Direction  tdata (low bit up)                              tuser (low bit up)
// s_axis   in         write_data[31:0], pin_levels[47:32]            mode[0], port_index[3:1],
//                                                                    reg_select[7:4]
// m_axis   out        read_data[31:0], pin_drive[47:32],             none
//                     output_enable[63:48], port_locked[64], zero fill
//
// Each transaction is captured when accepted; the controller then runs the register update
// in its execute state and loads the result register.
// A new transaction is taken while the previous result drains on the same cycle.
// Reset is synchronous and clears every port register and lock sequence.
// A stalled result holds in its register and blocks further input until taken.
module gpio_port_register_block
  import gpio_prb_pkg::*;
#(
  parameter int PORT_COUNT = PORT_COUNT_DEF,
  parameter int PINS_PER_PORT = PINS_PER_PORT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // write_data, pin_levels
  input  logic [7:0]  s_tuser,  // mode, port_index, reg_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // read_data, pin_drive, output_enable, port_locked
);

  prb_cmd_t    cmd;
  logic [31:0] read_data;
  logic [15:0] pin_drive;
  logic [15:0] output_enable;
  logic        port_locked;

  gpio_prb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gpio_prb_datapath #(
    .PORT_COUNT    (PORT_COUNT),
    .PINS_PER_PORT (PINS_PER_PORT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_mode       (s_tuser[0]),
    .in_port_index (s_tuser[3:1]),
    .in_reg_select (s_tuser[7:4]),
    .in_write_data (s_tdata[31:0]),
    .in_pin_levels (s_tdata[47:32]),
    .read_data     (read_data),
    .pin_drive     (pin_drive),
    .output_enable (output_enable),
    .port_locked   (port_locked)
  );

  assign m_tdata = {7'h0, port_locked, output_enable, pin_drive, read_data};

endmodule

>>> rtl/gpio_prb_ctrl.sv
module gpio_prb_ctrl
  import gpio_prb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output prb_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic accept;

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign cmd.capture = accept;
  assign cmd.execute = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && m_tready) out_valid_next = 1'b0;
    if (state == ST_EXEC) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted transaction not executed");
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> out_valid)
    else $error("executed transaction gave no result");
  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !out_valid)
    else $error("result register overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !s_tready)
    else $error("input taken while executing");

endmodule

>>> rtl/gpio_prb_datapath.sv
module gpio_prb_datapath
  import gpio_prb_pkg::*;
#(
  parameter int PORT_COUNT = PORT_COUNT_DEF,
  parameter int PINS_PER_PORT = PINS_PER_PORT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  prb_cmd_t     cmd,
  input  logic         in_mode,
  input  logic [2:0]   in_port_index,
  input  logic [3:0]   in_reg_select,
  input  logic [31:0]  in_write_data,
  input  logic [15:0]  in_pin_levels,
  output logic [31:0]  read_data,
  output logic [15:0]  pin_drive,
  output logic [15:0]  output_enable,
  output logic         port_locked
);

  localparam int PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam logic [PIN_W-1:0] PIN_MASK =
    PIN_W'((17'd1 << PINS_PER_PORT) - 17'd1);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_CLEAR = 2'd2;

  logic [WORD_W-1:0] pin_mode_word [PORT_COUNT];
  logic [PIN_W-1:0]  output_type_bits [PORT_COUNT];
  logic [WORD_W-1:0] speed_word [PORT_COUNT];
  logic [WORD_W-1:0] pull_word [PORT_COUNT];
  logic [PIN_W-1:0]  output_latch [PORT_COUNT];
  logic [WORD_W-1:0] altfunc_low_word [PORT_COUNT];
  logic [WORD_W-1:0] altfunc_high_word [PORT_COUNT];
  logic [PIN_W:0]    lock_word [PORT_COUNT];
  logic [1:0]        lock_phase [PORT_COUNT];

  logic              wr_q;
  logic [2:0]        port_q;
  logic [3:0]        sel_q;
  logic [31:0]       data_q;
  logic [15:0]       lev_q;

  logic [PORT_SEL_W-1:0] port_ext;
  logic [PORT_W-1:0] idx;
  logic              port_ok;
  logic              do_write;
  logic [WORD_W-1:0] cur_mode;
  logic [PIN_W-1:0]  cur_type;
  logic [WORD_W-1:0] cur_speed;
  logic [WORD_W-1:0] cur_pull;
  logic [PIN_W-1:0]  cur_latch;
  logic [WORD_W-1:0] cur_aflow;
  logic [WORD_W-1:0] cur_afhigh;
  logic [PIN_W:0]    cur_lock;
  logic [1:0]        cur_phase;
  logic [PIN_W-1:0]  locked;
  logic [PIN_W-1:0]  free_pins;
  logic [WORD_W-1:0] free2;
  logic [PIN_W-1:0]  lk_pins;
  logic [PIN_W-1:0]  lk_held;
  logic              lk_key;
  logic [WORD_W-1:0] mode_next;
  logic [PIN_W-1:0]  type_next;
  logic [WORD_W-1:0] speed_next;
  logic [WORD_W-1:0] pull_next;
  logic [PIN_W-1:0]  latch_next;
  logic [WORD_W-1:0] aflow_next;
  logic [WORD_W-1:0] afhigh_next;
  logic [PIN_W:0]    lock_next;
  logic [1:0]        phase_next;
  logic [WORD_W-1:0] rd;

  assign port_ext = {2'b00, port_q};
  assign port_ok = (port_ext < PORT_SEL_W'(PORT_COUNT));
  assign idx = port_ext[PORT_W-1:0];
  assign do_write = cmd.execute && port_ok && wr_q;

  assign cur_mode = pin_mode_word[idx];
  assign cur_type = output_type_bits[idx];
  assign cur_speed = speed_word[idx];
  assign cur_pull = pull_word[idx];
  assign cur_latch = output_latch[idx];
  assign cur_aflow = altfunc_low_word[idx];
  assign cur_afhigh = altfunc_high_word[idx];
  assign cur_lock = lock_word[idx];
  assign cur_phase = lock_phase[idx];

  assign locked = cur_lock[KEY_BIT] ? (cur_lock[PIN_W-1:0] & PIN_MASK) : '0;
  assign free_pins = PIN_MASK & ~locked;
  assign free2 = spread2(free_pins);
  assign lk_pins = data_q[PIN_W-1:0] & PIN_MASK;
  assign lk_held = cur_lock[PIN_W-1:0] & PIN_MASK;
  assign lk_key = data_q[KEY_BIT];

  always_comb begin
    mode_next = cur_mode;
    type_next = cur_type;
    speed_next = cur_speed;
    pull_next = cur_pull;
    latch_next = cur_latch;
    aflow_next = cur_aflow;
    afhigh_next = cur_afhigh;
    lock_next = cur_lock;
    phase_next = cur_phase;
    if (wr_q) begin
      case (sel_q)
        REG_MODE: mode_next = (cur_mode & ~free2) | (data_q & free2);
        REG_TYPE: type_next = (cur_type & ~free_pins) | (data_q[PIN_W-1:0] & free_pins);
        REG_SPEED: speed_next = (cur_speed & ~free2) | (data_q & free2);
        REG_PULL: pull_next = (cur_pull & ~free2) | (data_q & free2);
        REG_OUTPUT: latch_next = data_q[PIN_W-1:0] & PIN_MASK;
        REG_SETRESET: begin
          latch_next = ((cur_latch & ~data_q[31:16]) | data_q[15:0]) & PIN_MASK;
        end
        REG_LOCK: begin
          if (!cur_lock[KEY_BIT]) begin
            if (cur_phase == PH_FIRST && !lk_key && lk_pins == lk_held) begin
              phase_next = PH_CLEAR;
            end else if (cur_phase == PH_CLEAR && lk_key && lk_pins == lk_held) begin
              lock_next = {1'b1, lk_held};
              phase_next = PH_IDLE;
            end else begin
              lock_next = {1'b0, lk_pins};
              phase_next = lk_key ? PH_FIRST : PH_IDLE;
            end
          end
        end
        REG_AFLOW: begin
          aflow_next = (cur_aflow & ~spread4(free_pins[7:0]))
                     | (data_q & spread4(free_pins[7:0]));
        end
        REG_AFHIGH: begin
          afhigh_next = (cur_afhigh & ~spread4(free_pins[15:8]))
                      | (data_q & spread4(free_pins[15:8]));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd = '0;
    if (!wr_q) begin
      case (sel_q)
        REG_MODE: rd = cur_mode;
        REG_TYPE: rd = {16'h0, cur_type};
        REG_SPEED: rd = cur_speed;
        REG_PULL: rd = cur_pull;
        REG_INPUT: rd = {16'h0, lev_q & PIN_MASK};
        REG_OUTPUT: rd = {16'h0, cur_latch};
        REG_LOCK: rd = {15'h0, cur_lock};
        REG_AFLOW: rd = cur_aflow;
        REG_AFHIGH: rd = cur_afhigh;
        default: rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wr_q <= in_mode;
      port_q <= in_port_index;
      sel_q <= in_reg_select;
      data_q <= in_write_data;
      lev_q <= in_pin_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        pin_mode_word[i] <= '0;
        output_type_bits[i] <= '0;
        speed_word[i] <= '0;
        pull_word[i] <= '0;
        output_latch[i] <= '0;
        altfunc_low_word[i] <= '0;
        altfunc_high_word[i] <= '0;
        lock_word[i] <= '0;
        lock_phase[i] <= PH_IDLE;
      end
    end else if (do_write) begin
      pin_mode_word[idx] <= mode_next;
      output_type_bits[idx] <= type_next;
      speed_word[idx] <= speed_next;
      pull_word[idx] <= pull_next;
      output_latch[idx] <= latch_next;
      altfunc_low_word[idx] <= aflow_next;
      altfunc_high_word[idx] <= afhigh_next;
      lock_word[idx] <= lock_next;
      lock_phase[idx] <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (port_ok) begin
        read_data <= rd;
        pin_drive <= latch_next;
        output_enable <= outputs_enabled(mode_next);
        port_locked <= lock_next[KEY_BIT];
      end else begin
        read_data <= '0;
        pin_drive <= '0;
        output_enable <= '0;
        port_locked <= 1'b0;
      end
    end
  end

endmodule

>>> verif/tb_gpio_port_register_block.sv
module tb_gpio_port_register_block;
  import gpio_prb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACC_READ = 1'b0;
  localparam logic ACC_WRITE = 1'b1;
  localparam logic [15:0] PIN_MASK = 16'((32'h1 << PINS_PER_PORT_DEF) - 1);
  localparam int STALL_AT_REPLY = 150;
  localparam int STALL_CYCLES = 100;
  localparam int QUIET_TAIL = 50;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {
    LOCK_IDLE,
    LOCK_KEY_SET,
    LOCK_KEY_CLEARED
  } lock_phase_t;

  typedef struct packed {
    logic        is_write;
    logic [2:0]  port;
    logic [3:0]  sel;
    logic [31:0] wdata;
    logic [15:0] levels;
  } access_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic        locked;
    logic [15:0] enable;
    logic [15:0] drive;
    logic [31:0] read_data;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // write_data, pin_levels
  logic [7:0]  s_tuser = '0;  // mode, port_index, reg_select
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;       // read_data, pin_drive, output_enable, port_locked

  logic [31:0] mode_regs [PORT_COUNT_DEF];
  logic [15:0] type_regs [PORT_COUNT_DEF];
  logic [31:0] speed_regs [PORT_COUNT_DEF];
  logic [31:0] pull_regs [PORT_COUNT_DEF];
  logic [15:0] out_latch [PORT_COUNT_DEF];
  logic [31:0] af_low_regs [PORT_COUNT_DEF];
  logic [31:0] af_high_regs [PORT_COUNT_DEF];
  logic [16:0] lock_regs [PORT_COUNT_DEF];
  lock_phase_t lock_phase [PORT_COUNT_DEF];

  access_t pending_accesses[$];
  reply_t  expected_replies[$];
  int      total_accesses = 0;
  int      sent_accesses = 0;
  int      mismatches = 0;

  gpio_port_register_block u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic reply_t predict_port_access(access_t a);
    reply_t      r;
    logic [15:0] locked;
    logic [15:0] free_pins;
    logic [15:0] pins;
    logic [15:0] held;
    logic [31:0] mask2;
    logic [31:0] mask4_lo;
    logic [31:0] mask4_hi;
    logic        key;
    r = '0;
    if (a.port >= PORT_COUNT_DEF) return r;
    locked = lock_regs[a.port][16] ? (lock_regs[a.port][15:0] & PIN_MASK) : 16'h0;
    free_pins = PIN_MASK & ~locked;
    for (int p = 0; p < 16; p++) mask2[2*p +: 2] = {2{free_pins[p]}};
    for (int p = 0; p < 8; p++) begin
      mask4_lo[4*p +: 4] = {4{free_pins[p]}};
      mask4_hi[4*p +: 4] = {4{free_pins[p+8]}};
    end
    if (a.is_write == ACC_WRITE) begin
      case (a.sel)
        REG_MODE: mode_regs[a.port] = (mode_regs[a.port] & ~mask2) | (a.wdata & mask2);
        REG_TYPE: begin
          type_regs[a.port] = (type_regs[a.port] & ~free_pins) | (a.wdata[15:0] & free_pins);
        end
        REG_SPEED: speed_regs[a.port] = (speed_regs[a.port] & ~mask2) | (a.wdata & mask2);
        REG_PULL: pull_regs[a.port] = (pull_regs[a.port] & ~mask2) | (a.wdata & mask2);
        REG_OUTPUT: out_latch[a.port] = a.wdata[15:0] & PIN_MASK;
        REG_SETRESET: begin
          out_latch[a.port] = ((out_latch[a.port] & ~a.wdata[31:16]) | a.wdata[15:0]) & PIN_MASK;
        end
        REG_LOCK: begin
          pins = a.wdata[15:0] & PIN_MASK;
          key = a.wdata[KEY_BIT];
          held = lock_regs[a.port][15:0] & PIN_MASK;
          if (!lock_regs[a.port][16]) begin
            if (lock_phase[a.port] == LOCK_KEY_SET && !key && pins == held) begin
              lock_phase[a.port] = LOCK_KEY_CLEARED;
            end else if (lock_phase[a.port] == LOCK_KEY_CLEARED && key && pins == held) begin
              lock_regs[a.port] = {1'b1, held};
              lock_phase[a.port] = LOCK_IDLE;
            end else if (key) begin
              lock_regs[a.port] = {1'b0, pins};
              lock_phase[a.port] = LOCK_KEY_SET;
            end else begin
              lock_regs[a.port] = {1'b0, pins};
              lock_phase[a.port] = LOCK_IDLE;
            end
          end
        end
        REG_AFLOW: begin
          af_low_regs[a.port] = (af_low_regs[a.port] & ~mask4_lo) | (a.wdata & mask4_lo);
        end
        REG_AFHIGH: begin
          af_high_regs[a.port] = (af_high_regs[a.port] & ~mask4_hi) | (a.wdata & mask4_hi);
        end
        default: ;
      endcase
    end else begin
      case (a.sel)
        REG_MODE: r.read_data = mode_regs[a.port];
        REG_TYPE: r.read_data = {16'h0, type_regs[a.port]};
        REG_SPEED: r.read_data = speed_regs[a.port];
        REG_PULL: r.read_data = pull_regs[a.port];
        REG_INPUT: r.read_data = {16'h0, a.levels & PIN_MASK};
        REG_OUTPUT: r.read_data = {16'h0, out_latch[a.port]};
        REG_LOCK: r.read_data = {15'h0, lock_regs[a.port]};
        REG_AFLOW: r.read_data = af_low_regs[a.port];
        REG_AFHIGH: r.read_data = af_high_regs[a.port];
        default: r.read_data = '0;
      endcase
    end
    r.drive = out_latch[a.port];
    for (int p = 0; p < 16; p++) r.enable[p] = (mode_regs[a.port][2*p +: 2] == 2'b01);
    r.locked = lock_regs[a.port][16];
    return r;
  endfunction

  task automatic add_access(input logic is_write, input logic [2:0] port,
                            input logic [3:0] sel, input logic [31:0] wdata,
                            input logic [15:0] levels);
    access_t a;
    a.is_write = is_write;
    a.port = port;
    a.sel = sel;
    a.wdata = wdata;
    a.levels = levels;
    pending_accesses.push_back(a);
  endtask

  task automatic add_lock_sequence(input logic [2:0] port, input bit broken);
    logic [15:0] pins;
    logic [31:0] w;
    pins = 16'($urandom) & 16'($urandom);
    w = $urandom;
    add_access(ACC_WRITE, port, REG_LOCK, {w[31:17], 1'b1, pins}, 16'($urandom));
    w = $urandom;
    if (broken && $urandom_range(0, 1) == 0) begin
      add_access(ACC_WRITE, port, REG_LOCK,
                 {w[31:17], 1'b0, pins ^ (16'h1 << $urandom_range(0, 15))},
                 16'($urandom));
    end else if (broken) begin
      add_access(ACC_WRITE, port, REG_LOCK, {w[31:17], 1'b1, pins}, 16'($urandom));
    end else begin
      add_access(ACC_WRITE, port, REG_LOCK, {w[31:17], 1'b0, pins}, 16'($urandom));
    end
    w = $urandom;
    add_access(ACC_WRITE, port, REG_LOCK, {w[31:17], 1'b1, pins}, 16'($urandom));
    add_access(ACC_READ, port, REG_LOCK, $urandom, 16'($urandom));
  endtask

  function automatic logic [2:0] pick_port();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(PORT_COUNT_DEF, 7));
    return 3'($urandom_range(0, PORT_COUNT_DEF - 1));
  endfunction

  always @(posedge clk) begin : access_driver
    access_t cur;
    int      gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(predict_port_access(cur));
        sent_accesses++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_accesses.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_accesses.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 3);
          s_tvalid <= 1'b0;
        end else begin
          cur = pending_accesses.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur.levels, cur.wdata};
          s_tuser <= {cur.sel, cur.port, cur.is_write};
        end
      end
    end
  end

  always @(posedge clk) begin : reply_monitor
    reply_t got;
    reply_t want;
    int     replies_seen;
    int     stall_left;
    int     gap_left;
    if (rst) begin
      m_tready <= 1'b0;
      replies_seen = 0;
      stall_left = 0;
      gap_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_replies.size() == 0) begin
          if (mismatches < 10) $display("unexpected reply: %h", got);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("bad reply: exp rd=%h drv=%h oe=%h lk=%b fill=%h",
                       want.read_data, want.drive, want.enable, want.locked, want.fill);
              $display("           got rd=%h drv=%h oe=%h lk=%b fill=%h",
                       got.read_data, got.drive, got.enable, got.locked, got.fill);
            end
            mismatches++;
          end
        end
        replies_seen++;
        if (replies_seen == STALL_AT_REPLY) stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else if (pending_accesses.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("gpio_port_register_block: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    for (int p = 0; p < PORT_COUNT_DEF; p++) begin
      mode_regs[p] = '0;
      type_regs[p] = '0;
      speed_regs[p] = '0;
      pull_regs[p] = '0;
      out_latch[p] = '0;
      af_low_regs[p] = '0;
      af_high_regs[p] = '0;
      lock_regs[p] = '0;
      lock_phase[p] = LOCK_IDLE;
    end

    add_access(ACC_WRITE, 3'd0, REG_MODE, 32'h5555_5555, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_TYPE, 32'hFFFF_FFFF, 16'hFFFF);
    add_access(ACC_WRITE, 3'd0, REG_SPEED, 32'hFFFF_FFFF, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_PULL, 32'hAAAA_AAAA, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_OUTPUT, 32'hFFFF_FFFF, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_SETRESET, 32'hFFFF_0000, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_SETRESET, 32'hFFFF_FFFF, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_AFLOW, 32'hFFFF_FFFF, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_AFHIGH, 32'h1234_5678, 16'h0000);
    add_access(ACC_WRITE, 3'd0, REG_INPUT, 32'hFFFF_FFFF, 16'hFFFF);
    add_access(ACC_WRITE, 3'd0, 4'd12, 32'hFFFF_FFFF, 16'hFFFF);
    for (int s = 0; s <= REG_AFHIGH; s++) begin
      add_access(ACC_READ, 3'd0, 4'(s), 32'hFFFF_FFFF, 16'hFFFF);
    end
    add_access(ACC_READ, 3'd0, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
    add_access(ACC_WRITE, 3'd6, REG_OUTPUT, 32'hFFFF_FFFF, 16'hFFFF);
    add_access(ACC_READ, 3'd7, REG_INPUT, 32'h0000_0000, 16'hFFFF);
    add_access(ACC_WRITE, 3'd1, REG_MODE, 32'h5555_5555, 16'h0000);
    add_access(ACC_WRITE, 3'd1, REG_LOCK, 32'h0001_00FF, 16'h0000);
    add_access(ACC_WRITE, 3'd1, REG_LOCK, 32'h0000_00FF, 16'h0000);
    add_access(ACC_WRITE, 3'd1, REG_LOCK, 32'h0001_00FF, 16'h0000);
    add_access(ACC_WRITE, 3'd1, REG_MODE, 32'h0000_0000, 16'h0000);
    add_access(ACC_READ, 3'd1, REG_MODE, 32'h0000_0000, 16'h0000);

    while (pending_accesses.size() < 430) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_lock_sequence(3'($urandom_range(0, PORT_COUNT_DEF - 1)), $urandom_range(0, 3) == 0);
      end else if (pick < 10) begin
        add_access(ACC_WRITE, pick_port(), REG_SETRESET, $urandom, 16'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        add_access(1'($urandom), pick_port(), 4'($urandom_range(10, 15)), $urandom,
                   16'($urandom));
      end else begin
        add_access(1'($urandom), pick_port(), 4'($urandom_range(0, 9)), $urandom,
                   16'($urandom));
      end
    end
    total_accesses = pending_accesses.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (sent_accesses == total_accesses && expected_replies.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("gpio_port_register_block: match");
    end else begin
      $display("gpio_port_register_block: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/gpio_prb_pkg.sv
rtl/gpio_prb_ctrl.sv
rtl/gpio_prb_datapath.sv
rtl/gpio_port_register_block.sv
verif/tb_gpio_port_register_block.sv
